[rtl/core/sti_pkg.sv]
// shared constants for the segment / triangle intersection pipeline
// no dependencies; used by sti_div and segment_triangle_intersect
package sti_pkg;

  localparam int OFF_LOG = 40;
  localparam int DIV_LAT = OFF_LOG + 3;
  localparam int TOL_W = 10;
  localparam logic [TOL_W-1:0] TOL_RESET = 10'd1;

endpackage

[rtl/core/segment_triangle_intersect.sv]
// Segment / triangle intersection test: exact fixed-point Moller-Trumbore with a
// fully pipelined datapath. One transaction is accepted per clock cycle; most of the
// pipeline's depth lies in the restoring divider that produces one bit of the hit
// offset per stage.
// The whole pipeline stalls only when a finished result is held and not taken.
// Depends on sti_pkg and sti_div.
module segment_triangle_intersect #(
  parameter int COORD_BITS = 21
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [sti_pkg::TOL_W-1:0]      cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [3*COORD_BITS-1:0]        seg_start,
  input  logic [3*COORD_BITS-1:0]        seg_end,
  input  logic [3*COORD_BITS-1:0]        vert_a,
  input  logic [3*COORD_BITS-1:0]        vert_b,
  input  logic [3*COORD_BITS-1:0]        vert_c,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           hit,
  output logic signed [COORD_BITS-1:0]   hit_x,
  output logic signed [COORD_BITS-1:0]   hit_y,
  output logic signed [COORD_BITS-1:0]   hit_z
);

  localparam int CB   = COORD_BITS;
  localparam int DW   = CB + 1;
  localparam int XW   = 2 * DW + 1;
  localparam int PW   = XW + DW + 3;
  localparam int TL   = PW / 2;
  localparam int TH   = PW - TL;
  localparam int NW   = PW + DW + 2;
  localparam int DENW = PW + 1;
  localparam int QW   = sti_pkg::OFF_LOG + 1;
  localparam int HW   = sti_pkg::OFF_LOG + 3;
  localparam int DL   = sti_pkg::DIV_LAT;
  localparam int L    = 11 + DL;
  localparam int RW   = 3 * CB;
  localparam int SBW  = 4 * RW;
  localparam logic signed [HW-1:0] P_HI = HW'((64'sd1 <<< (CB - 1)) - 64'sd1);
  localparam logic signed [HW-1:0] P_LO = -P_HI - HW'(1);

  function automatic logic signed [CB-1:0] crd(input logic [RW-1:0] r, input int k);
    crd = $signed(r[CB*(3-k)-1 -: CB]);
  endfunction

  logic [sti_pkg::TOL_W-1:0] tol;
  logic                      adv;
  logic                      vld [0:L-1];
  logic [SBW-1:0]            sb  [0:L-2];
  logic [3:0]                fl  [6:L-2];

  // stage registers
  logic signed [DW-1:0]      dv1 [3], e1_1 [3], e2_1 [3], s_1 [3];
  logic signed [DW-1:0]      dv2 [3], e1_2 [3], e2_2 [3], s_2 [3];
  logic signed [2*DW-1:0]    p1a [3], p1b [3], p2a [3], p2b [3];
  logic signed [DW-1:0]      dv3 [3], e1_3 [3], e2_3 [3], s_3 [3];
  logic signed [XW-1:0]      x1 [3], x2 [3];
  logic signed [DW-1:0]      dv4 [3], dv5 [3], dv6 [3];
  logic signed [XW+DW-1:0]   pd [3], pt [3], pu [3], pv [3];
  logic signed [PW-1:0]      det5, tn5, u5, v5;
  logic signed [PW-1:0]      det6, tn6, u6, v6;
  logic                      zero6;
  logic [PW-1:0]             det7, tm7;
  logic [DW-1:0]             mag7 [3];
  logic [PW-1:0]             det8;
  logic [TL+DW-1:0]          pl8 [3];
  logic [TH+DW-1:0]          ph8 [3];
  logic [NW-1:0]             num9 [3];
  logic [DENW-1:0]           den9;
  logic [QW-1:0]             q [3];
  logic signed [HW-1:0]      pt_b [3];

  assign adv       = !vld[L-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[L-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= sti_pkg::TOL_RESET;
    end else if (cfg_wr_en) begin
      tol <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < L; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int i = 1; i < L; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb[0] <= {seg_start, vert_a, vert_b, vert_c};
      for (int i = 1; i < L - 1; i++) sb[i] <= sb[i-1];
      for (int i = 7; i < L - 1; i++) fl[i] <= fl[i-1];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_axis
    localparam int I1 = (k + 1) % 3;
    localparam int I2 = (k + 2) % 3;
    always_ff @(posedge clk) begin
      if (adv) begin
        // edges and direction
        dv1[k]  <= DW'(crd(seg_end, k)) - DW'(crd(seg_start, k));
        e1_1[k] <= DW'(crd(vert_b, k)) - DW'(crd(vert_a, k));
        e2_1[k] <= DW'(crd(vert_c, k)) - DW'(crd(vert_a, k));
        s_1[k]  <= DW'(crd(seg_start, k)) - DW'(crd(vert_a, k));
        // cross product terms
        p1a[k] <= (2*DW)'(dv1[I1]) * (2*DW)'(e2_1[I2]);
        p1b[k] <= (2*DW)'(dv1[I2]) * (2*DW)'(e2_1[I1]);
        p2a[k] <= (2*DW)'(s_1[I1]) * (2*DW)'(e1_1[I2]);
        p2b[k] <= (2*DW)'(s_1[I2]) * (2*DW)'(e1_1[I1]);
        dv2[k] <= dv1[k]; e1_2[k] <= e1_1[k]; e2_2[k] <= e2_1[k]; s_2[k] <= s_1[k];
        x1[k] <= XW'(p1a[k]) - XW'(p1b[k]);
        x2[k] <= XW'(p2a[k]) - XW'(p2b[k]);
        dv3[k] <= dv2[k]; e1_3[k] <= e1_2[k]; e2_3[k] <= e2_2[k]; s_3[k] <= s_2[k];
        // dot product terms
        pd[k] <= (XW+DW)'(x1[k]) * (XW+DW)'(e1_3[k]);
        pt[k] <= (XW+DW)'(x2[k]) * (XW+DW)'(e2_3[k]);
        pu[k] <= (XW+DW)'(x1[k]) * (XW+DW)'(s_3[k]);
        pv[k] <= (XW+DW)'(x2[k]) * (XW+DW)'(dv3[k]);
        dv4[k] <= dv3[k];
        dv5[k] <= dv4[k];
        dv6[k] <= dv5[k];
        mag7[k] <= dv6[k] < 0 ? DW'(-dv6[k]) : DW'(dv6[k]);
        pl8[k] <= (TL+DW)'(tm7[TL-1:0]) * (TL+DW)'(mag7[k]);
        ph8[k] <= (TH+DW)'(tm7[PW-1:TL]) * (TH+DW)'(mag7[k]);
        num9[k] <= NW'({ph8[k], {TL{1'b0}}, 1'b0}) + NW'({pl8[k], 1'b0}) + NW'(det8);
      end
    end

    sti_div #(.NW(NW), .DENW(DENW)) u_div (
      .clk (clk),
      .en  (adv),
      .num (num9[k]),
      .den (den9),
      .quo (q[k])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      det5 <= PW'(pd[0]) + PW'(pd[1]) + PW'(pd[2]);
      tn5  <= PW'(pt[0]) + PW'(pt[1]) + PW'(pt[2]);
      u5   <= PW'(pu[0]) + PW'(pu[1]) + PW'(pu[2]);
      v5   <= PW'(pv[0]) + PW'(pv[1]) + PW'(pv[2]);
      // fold the determinant sign into all terms
      zero6 <= det5 == '0;
      det6  <= det5 < 0 ? -det5 : det5;
      tn6   <= det5 < 0 ? -tn5 : tn5;
      u6    <= det5 < 0 ? -u5 : u5;
      v6    <= det5 < 0 ? -v5 : v5;
      det7  <= PW'(det6);
      tm7   <= tn6 < 0 ? PW'(-tn6) : PW'(tn6);
      fl[6] <= {zero6 || tn6 > det6 || u6 < 0 || u6 > det6 || v6 < 0 || v6 > det6
                || (PW+1)'(u6) + (PW+1)'(v6) > (PW+1)'(det6),
                (tn6 < 0) != (dv6[0] < 0),
                (tn6 < 0) != (dv6[1] < 0),
                (tn6 < 0) != (dv6[2] < 0)};
      det8 <= det7;
      den9 <= {det8, 1'b0};
    end
  end

  // hit point before saturation
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        pt_b[k] <= HW'(crd(sb[L-3][SBW-1 -: RW], k))
                   + (fl[L-3][2-k] ? -$signed(HW'(q[k])) : $signed(HW'(q[k])));
      end
    end
  end

  logic                  near;
  logic signed [CB-1:0]  sat [3];

  always_comb begin
    logic signed [HW:0] d;
    logic [HW:0]        m;
    logic               all_in;
    near = 1'b0;
    for (int j = 0; j < 3; j++) begin
      all_in = 1'b1;
      for (int k = 0; k < 3; k++) begin
        d = (HW+1)'(pt_b[k]) - (HW+1)'(crd(sb[L-2][RW*(3-j)-1 -: RW], k));
        m = d < 0 ? (HW+1)'(-d) : (HW+1)'(d);
        if (m >= (HW+1)'(tol)) all_in = 1'b0;
      end
      near = near || all_in;
    end
    for (int k = 0; k < 3; k++) begin
      if (pt_b[k] > P_HI) sat[k] = CB'(P_HI);
      else if (pt_b[k] < P_LO) sat[k] = CB'(P_LO);
      else sat[k] = CB'(pt_b[k]);
    end
  end

  logic hit_w;
  assign hit_w = !fl[L-2][3] && !near;

  always_ff @(posedge clk) begin
    if (adv) begin
      hit   <= hit_w;
      hit_x <= hit_w ? sat[0] : '0;
      hit_y <= hit_w ? sat[1] : '0;
      hit_z <= hit_w ? sat[2] : '0;
    end
  end

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> hit_x == '0 && hit_y == '0 && hit_z == '0)
    else $error("miss with nonzero point");

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0])
    else $error("accepted transaction lost at entry");

endmodule

[rtl/core/sti_div.sv]
// pipelined restoring divider, one quotient bit per stage, result clamped to 2^OFF_LOG
// depends on sti_pkg
module sti_div #(
  parameter int NW = 94,
  parameter int DENW = 71
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [NW-1:0]                 num,
  input  logic [DENW-1:0]               den,
  output logic [sti_pkg::OFF_LOG:0]     quo
);

  localparam int ST = sti_pkg::OFF_LOG + 1;
  localparam logic [ST-1:0] LIM = {1'b1, {(ST-1){1'b0}}};

  logic [DENW-1:0] rem [0:ST-1];
  logic [ST-1:0]   qb  [0:ST];
  logic [ST-1:0]   nl  [0:ST-1];
  logic [DENW-1:0] dn  [0:ST-1];
  logic            ov  [0:ST];
  logic [NW-1:0]   top;
  logic            ovf;

  always_comb begin
    top = num >> ST;
    ovf = top >= NW'(den);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= DENW'(top);
      ov[0]  <= ovf;
      nl[0]  <= num[ST-1:0];
      dn[0]  <= den;
      qb[0]  <= '0;
    end
  end

  for (genvar k = 1; k <= ST; k++) begin : g_step
    logic [DENW:0] trial;
    logic [DENW:0] diff;
    logic          ge;
    logic [ST-1:0] qb_next;
    always_comb begin
      trial = {rem[k-1], nl[k-1][ST-k]};
      ge    = trial >= {1'b0, dn[k-1]};
      diff  = trial - {1'b0, dn[k-1]};
      qb_next = qb[k-1];
      qb_next[ST-k] = ge;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        qb[k] <= qb_next;
        ov[k] <= ov[k-1];
      end
    end
    if (k < ST) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= ge ? DENW'(diff) : DENW'(trial);
          nl[k]  <= nl[k-1];
          dn[k]  <= dn[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= (ov[ST] || qb[ST] > LIM) ? LIM : qb[ST];
    end
  end

endmodule

[bench/tb_segment_triangle_intersect.sv]
// testbench for segment_triangle_intersect: directed and random segment / triangle
// queries checked against an exact fixed-point intersection predictor
// depends on sti_pkg and the segment_triangle_intersect rtl
`timescale 1ns / 1ps

module tb_segment_triangle_intersect;

  localparam int CB = 21;
  localparam int LATENCY = 11 + sti_pkg::DIV_LAT;
  localparam int STALL_LIMIT = 4000;
  localparam longint OFF_MAX = longint'(1) << sti_pkg::OFF_LOG;

  typedef struct packed {
    logic hit;
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] z;
  } isect_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_wr_en = 0;
  logic [sti_pkg::TOL_W-1:0] cfg_wr_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [3*CB-1:0] seg_start = '0, seg_end = '0, vert_a = '0, vert_b = '0, vert_c = '0;
  logic out_valid;
  logic out_ready = 0;
  logic hit;
  logic signed [CB-1:0] hit_x, hit_y, hit_z;

  isect_t expected_hits[$];
  int tol_model = sti_pkg::TOL_RESET;
  int send_idle = 0, recv_idle = 0;
  bit hold_req = 0;
  int mismatches = 0;
  int stall_cycles = 0;

  segment_triangle_intersect uut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .seg_start(seg_start), .seg_end(seg_end),
    .vert_a(vert_a), .vert_b(vert_b), .vert_c(vert_c),
    .out_valid(out_valid), .out_ready(out_ready),
    .hit(hit), .hit_x(hit_x), .hit_y(hit_y), .hit_z(hit_z)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic longint coord(logic [3*CB-1:0] r, int k);
    logic signed [CB-1:0] f;
    f = r[CB*(2-k) +: CB];
    return longint'(f);
  endfunction

  function automatic logic signed [127:0] w(longint v);
    return 128'(v);
  endfunction

  function automatic bit near_vertex(longint p0, longint p1, longint p2,
                                     logic [3*CB-1:0] vx);
    longint d0, d1, d2;
    d0 = p0 - coord(vx, 0);
    d1 = p1 - coord(vx, 1);
    d2 = p2 - coord(vx, 2);
    if (d0 < 0) d0 = -d0;
    if (d1 < 0) d1 = -d1;
    if (d2 < 0) d2 = -d2;
    return d0 < tol_model && d1 < tol_model && d2 < tol_model;
  endfunction

  function automatic isect_t predict_intersection(logic [3*CB-1:0] so, eo, av, bv, cv);
    longint o[3], dv[3], e1[3], e2[3], sv[3], s1[3], s2[3], p[3];
    logic signed [127:0] det, tn, uu, vv, tm, num, q;
    longint qm, dm, hi_lim, lo_lim;
    bit tneg;
    isect_t r;
    r = '0;
    hi_lim = (longint'(1) << (CB-1)) - 1;
    lo_lim = -(longint'(1) << (CB-1));
    for (int k = 0; k < 3; k++) begin
      o[k] = coord(so, k);
      dv[k] = coord(eo, k) - o[k];
      e1[k] = coord(bv, k) - coord(av, k);
      e2[k] = coord(cv, k) - coord(av, k);
      sv[k] = o[k] - coord(av, k);
    end
    s1[0] = dv[1]*e2[2] - dv[2]*e2[1];
    s1[1] = dv[2]*e2[0] - dv[0]*e2[2];
    s1[2] = dv[0]*e2[1] - dv[1]*e2[0];
    s2[0] = sv[1]*e1[2] - sv[2]*e1[1];
    s2[1] = sv[2]*e1[0] - sv[0]*e1[2];
    s2[2] = sv[0]*e1[1] - sv[1]*e1[0];
    det = w(s1[0])*w(e1[0]) + w(s1[1])*w(e1[1]) + w(s1[2])*w(e1[2]);
    tn = w(s2[0])*w(e2[0]) + w(s2[1])*w(e2[1]) + w(s2[2])*w(e2[2]);
    uu = w(s1[0])*w(sv[0]) + w(s1[1])*w(sv[1]) + w(s1[2])*w(sv[2]);
    vv = w(s2[0])*w(dv[0]) + w(s2[1])*w(dv[1]) + w(s2[2])*w(dv[2]);
    if (det == 0) return r;
    if (det < 0) begin
      det = -det; tn = -tn; uu = -uu; vv = -vv;
    end
    if (tn > det || uu < 0 || uu > det || vv < 0 || vv > det || uu + vv > det) return r;
    tneg = tn < 0;
    tm = tneg ? -tn : tn;
    for (int k = 0; k < 3; k++) begin
      dm = dv[k] < 0 ? -dv[k] : dv[k];
      num = tm * w(dm);
      q = (2*num + det) / (2*det);
      qm = (q > w(OFF_MAX)) ? OFF_MAX : longint'(q[63:0]);
      p[k] = o[k] + ((tneg != (dv[k] < 0)) ? -qm : qm);
    end
    if (near_vertex(p[0], p[1], p[2], av) || near_vertex(p[0], p[1], p[2], bv) ||
        near_vertex(p[0], p[1], p[2], cv)) return r;
    for (int k = 0; k < 3; k++) begin
      if (p[k] > hi_lim) p[k] = hi_lim;
      if (p[k] < lo_lim) p[k] = lo_lim;
    end
    r.hit = 1;
    r.x = p[0][CB-1:0];
    r.y = p[1][CB-1:0];
    r.z = p[2][CB-1:0];
    return r;
  endfunction

  function automatic logic [3*CB-1:0] pack3(longint x, longint y, longint z);
    return {x[CB-1:0], y[CB-1:0], z[CB-1:0]};
  endfunction

  function automatic longint rnd(int span);
    return longint'($urandom_range(2*span)) - span;
  endfunction

  function automatic logic [3*CB-1:0] rnd_raw();
    return (3*CB)'({$urandom, $urandom});
  endfunction

  task automatic send_query(logic [3*CB-1:0] so, eo, av, bv, cv);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1;
    seg_start <= so; seg_end <= eo; vert_a <= av; vert_b <= bv; vert_c <= cv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_hits = {expected_hits, predict_intersection(so, eo, av, bv, cv)};
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    @(posedge clk);
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_tolerance(int value);
    wait_drained();
    cfg_wr_en <= 1;
    cfg_wr_data <= value[sti_pkg::TOL_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 0;
    tol_model = value;
  endtask

  // segment aimed at a triangle vertex or at a point in the triangle, with random reach
  task automatic send_aimed(int span, int vertex_pick);
    longint a[3], b[3], c[3], s[3], e[3], pt[3];
    int w1, w2, f;
    w1 = $urandom_range(1024);
    w2 = $urandom_range(1024 - w1);
    f = $urandom_range(4);
    for (int k = 0; k < 3; k++) begin
      a[k] = rnd(span); b[k] = rnd(span); c[k] = rnd(span); s[k] = rnd(span);
    end
    for (int k = 0; k < 3; k++) begin
      case (vertex_pick)
        1: pt[k] = a[k];
        2: pt[k] = b[k];
        3: pt[k] = c[k];
        default: pt[k] = a[k] + (w1*(b[k]-a[k]) + w2*(c[k]-a[k])) / 1024;
      endcase
      case (f)
        0: e[k] = pt[k];
        1: e[k] = s[k] + 2*(pt[k]-s[k]);
        2: e[k] = s[k] - (pt[k]-s[k]);
        3: e[k] = s[k] + (pt[k]-s[k]) / 2;
        default: e[k] = pt[k] + rnd(span/8);
      endcase
    end
    send_query(pack3(s[0], s[1], s[2]), pack3(e[0], e[1], e[2]),
               pack3(a[0], a[1], a[2]), pack3(b[0], b[1], b[2]), pack3(c[0], c[1], c[2]));
  endtask

  task automatic send_mixed(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9)) inside
        0, 1: send_query(rnd_raw(), rnd_raw(), rnd_raw(), rnd_raw(), rnd_raw());
        2: send_aimed(1 << 8, $urandom_range(1, 3));
        3: send_aimed(1 << 17, $urandom_range(1, 3));
        4: send_aimed(1 << 6, 0);
        default: send_aimed(1 << 17, 0);
      endcase
    end
  endtask

  task automatic test_directed();
    logic [3*CB-1:0] p0, p1, p2, mx, mn;
    p0 = pack3(0, 0, 0);
    p1 = pack3(1024, 0, 0);
    p2 = pack3(0, 1024, 0);
    mx = pack3(1048575, 1048575, 1048575);
    mn = pack3(-1048576, -1048576, -1048576);
    send_query('0, '0, '0, '0, '0);
    send_query('1, '1, '1, '1, '1);
    send_query(pack3(100, 100, -500), pack3(100, 100, -500), p0, p1, p2);
    send_query(pack3(100, 100, -500), pack3(100, 100, 500), p0, p1, p1);
    send_query(pack3(100, 100, -500), pack3(100, 100, 500), p0, p1, p2);
    send_query(pack3(100, 100, 500), pack3(100, 100, -500), p0, p1, p2);
    send_query(pack3(100, 100, -500), pack3(100, 100, -200), p0, p1, p2);
    send_query(pack3(100, 100, 500), pack3(100, 100, 1000), p0, p1, p2);
    send_query(pack3(0, 0, -500), pack3(0, 0, 500), p0, p1, p2);
    send_query(pack3(1024, 0, -5), pack3(1024, 0, 5), p0, p1, p2);
    send_query(pack3(1, 0, -5), pack3(1, 0, 5), p0, p1, p2);
    send_query(pack3(512, 512, -5), pack3(512, 512, 5), p0, p1, p2);
    send_query(pack3(2000, 2000, -5), pack3(2000, 2000, 5), p0, p1, p2);
    send_query(pack3(100, 100, 3), pack3(100, 100, 0), p0, p1, p2);
    send_query(mn, mx, pack3(0, -1048576, 0), pack3(1048575, 1048575, 0),
               pack3(-1048576, 1048575, 0));
    send_query(pack3(1048575, 0, 1), pack3(1048575, 0, 2), p0, pack3(0, 4, 0),
               pack3(4, 0, 0));
    send_query(pack3(-1048576, 5, 1048575), pack3(-1048575, 5, 1048574), p0,
               pack3(0, 1048575, 0), pack3(0, 0, 1048575));
    send_query(mx, mn, mn, mx, pack3(1048575, -1048576, 0));
    send_query(pack3(0, 0, -1048576), pack3(0, 0, 1048575), pack3(-900000, -900000, 0),
               pack3(900000, -900000, 0), pack3(0, 900000, 0));
  endtask

  task automatic test_tolerance_extremes();
    write_tolerance(0);
    send_aimed(1 << 10, 1);
    send_aimed(1 << 10, 2);
    send_query(pack3(0, 0, -500), pack3(0, 0, 500), pack3(0, 0, 0), pack3(1024, 0, 0),
               pack3(0, 1024, 0));
    send_mixed(20);
    write_tolerance(1023);
    send_mixed(60);
    write_tolerance($urandom_range(2, 1022));
  endtask

  task automatic test_sender_heavy_idle();
    send_idle = 23; recv_idle = 75;
    send_mixed(380);
  endtask

  task automatic test_receiver_heavy_idle();
    write_tolerance($urandom_range(1, 64));
    send_idle = 75; recv_idle = 23;
    send_mixed(380);
  endtask

  task automatic test_back_to_back();
    write_tolerance(1);
    send_idle = 0; recv_idle = 0;
    send_mixed(300);
  endtask

  task automatic test_backpressure();
    hold_req = 1;
    send_mixed(120);
    wait_drained();
    send_mixed(40);
  endtask

  always @(posedge clk) begin
    if (hold_req) begin
      out_ready <= 0;
      repeat (300) @(posedge clk);
      hold_req = 0;
    end else begin
      out_ready <= !rst && ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    isect_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: hit=%0d x=%0d y=%0d z=%0d", hit, hit_x, hit_y, hit_z);
      end else begin
        want = expected_hits.pop_front();
        if (hit !== want.hit || hit_x !== want.x || hit_y !== want.y || hit_z !== want.z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected hit=%0d x=%0d y=%0d z=%0d, got hit=%0d x=%0d y=%0d z=%0d",
                     want.hit, want.x, want.y, want.z, hit, hit_x, hit_y, hit_z);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_tolerance_extremes();
    test_sender_heavy_idle();
    test_receiver_heavy_idle();
    test_back_to_back();
    test_backpressure();
    wait_drained();
    if (mismatches == 0 && expected_hits.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
